FILE: rtl/stpa_pkg.sv
// Shared types and constants for the sprite transformed pixel address block.
`timescale 1ns / 1ps

package stpa_pkg;

    // Field and register widths.
    localparam int FRAME_NUMBER_W = 16;
    localparam int COORD_W        = 10;
    localparam int FRAME_SIDE_W   = 9;
    localparam int SHEET_REG_W    = 13;
    localparam int ORIENT_W       = 3;
    localparam int ADDR_W         = 24;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 13;

    // Default limits on the frame and sheet sides.
    localparam int MAX_FRAME_SIDE_DEFAULT = 256;
    localparam int MAX_SHEET_SIDE_DEFAULT = 4096;

    // Reset values of the configuration registers.
    localparam logic [FRAME_SIDE_W-1:0] FRAME_WIDTH_RESET    = 9'd16;
    localparam logic [FRAME_SIDE_W-1:0] FRAME_HEIGHT_RESET   = 9'd16;
    localparam logic [SHEET_REG_W-1:0]  SHEET_WIDTH_RESET    = 13'd16;
    localparam logic [SHEET_REG_W-1:0]  SHEET_HEIGHT_RESET   = 13'd16;
    localparam logic [SHEET_REG_W-1:0]  FRAMES_PER_ROW_RESET = 13'd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH    = 3'd0,
        REG_FRAME_HEIGHT   = 3'd1,
        REG_SHEET_WIDTH    = 3'd2,
        REG_SHEET_HEIGHT   = 3'd3,
        REG_FRAMES_PER_ROW = 3'd4,
        REG_ORIENTATION    = 3'd5
    } cfg_reg_t;

    typedef enum logic [ORIENT_W-1:0] {
        ORIENT_NONE          = 3'd0,
        ORIENT_MIRROR_ROT180 = 3'd1,
        ORIENT_MIRROR        = 3'd2,
        ORIENT_ROT180        = 3'd3,
        ORIENT_MIRROR_ROT270 = 3'd4,
        ORIENT_ROT90         = 3'd5,
        ORIENT_ROT270        = 3'd6,
        ORIENT_MIRROR_ROT90  = 3'd7
    } orient_t;

endpackage

FILE: rtl/sprite_transformed_pixel_address.sv
// Sprite-sheet pixel address generator with eight orientations, fully pipelined.
// Each accepted request passes through the input stage, the frame-number divider,
// and the multiply, bound check and address multiply-add stages before it shows on
// m_valid. Throughput: one request per cycle while the skid register is empty.
// The 16-step divider pipeline sets the latency; the 12x13 address multiply sets the
// longest stage. Reset clears the pipeline and loads the configuration defaults.
`timescale 1ns / 1ps

module sprite_transformed_pixel_address
    import stpa_pkg::*;
#(
    parameter int MAX_FRAME_SIDE = MAX_FRAME_SIDE_DEFAULT,
    parameter int MAX_SHEET_SIDE = MAX_SHEET_SIDE_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    // Configuration write channel.
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,

    // Request channel.
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [FRAME_NUMBER_W-1:0] s_frame_number,
    input  logic signed [COORD_W-1:0] s_screen_x,
    input  logic signed [COORD_W-1:0] s_screen_y,

    // Result channel.
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [ADDR_W-1:0]         m_pixel_address,
    output logic                      m_in_range
);

    // The divider produces one quotient bit per stage.
    localparam int DIV_STEPS = FRAME_NUMBER_W;

    // Side caps. When the limit is at or above what the register can hold, the
    // cap is the all-ones value and never takes effect.
    localparam int FRAME_REG_MAX = (1 << FRAME_SIDE_W) - 1;
    localparam int SHEET_REG_MAX = (1 << SHEET_REG_W) - 1;
    localparam logic [FRAME_SIDE_W-1:0] FRAME_CAP =
        (MAX_FRAME_SIDE < FRAME_REG_MAX) ? FRAME_SIDE_W'(MAX_FRAME_SIDE) : '1;
    localparam logic [SHEET_REG_W-1:0] SHEET_CAP =
        (MAX_SHEET_SIDE < SHEET_REG_MAX) ? SHEET_REG_W'(MAX_SHEET_SIDE) : '1;

    // A sheet coordinate that passes the bound check is below MAX_SHEET_SIDE.
    localparam int SIDE_W   = $clog2(MAX_SHEET_SIDE);
    localparam int PX_W     = SHEET_REG_W + FRAME_SIDE_W;
    localparam int PY_W     = FRAME_NUMBER_W + FRAME_SIDE_W;
    localparam int APROD_W  = SIDE_W + SHEET_REG_W;
    localparam int ASUM_W   = APROD_W + 1;
    localparam int AEXT_W   = (ASUM_W > ADDR_W) ? ASUM_W : ADDR_W;

    // ------------------------------------------------------------------
    // Configuration registers. Writes to indexes past the list are dropped.
    // ------------------------------------------------------------------
    logic [FRAME_SIDE_W-1:0] frame_width_reg;
    logic [FRAME_SIDE_W-1:0] frame_height_reg;
    logic [SHEET_REG_W-1:0]  sheet_width_reg;
    logic [SHEET_REG_W-1:0]  sheet_height_reg;
    logic [SHEET_REG_W-1:0]  frames_per_row_reg;
    orient_t                 orientation_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg    <= FRAME_WIDTH_RESET;
            frame_height_reg   <= FRAME_HEIGHT_RESET;
            sheet_width_reg    <= SHEET_WIDTH_RESET;
            sheet_height_reg   <= SHEET_HEIGHT_RESET;
            frames_per_row_reg <= FRAMES_PER_ROW_RESET;
            orientation_reg    <= ORIENT_NONE;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:    frame_width_reg    <= cfg_data[FRAME_SIDE_W-1:0];
                REG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data[FRAME_SIDE_W-1:0];
                REG_SHEET_WIDTH:    sheet_width_reg    <= cfg_data[SHEET_REG_W-1:0];
                REG_SHEET_HEIGHT:   sheet_height_reg   <= cfg_data[SHEET_REG_W-1:0];
                REG_FRAMES_PER_ROW: frames_per_row_reg <= cfg_data[SHEET_REG_W-1:0];
                REG_ORIENTATION:    orientation_reg    <= orient_t'(cfg_data[ORIENT_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    // Effective configuration values. The user must change the configuration only while
    // the block is idle; the block itself does not enforce it. Every stage reads these directly.
    logic [FRAME_SIDE_W-1:0] fw_cap;
    logic [FRAME_SIDE_W-1:0] fh_cap;
    logic [SHEET_REG_W-1:0]  sw_cap;
    logic [SHEET_REG_W-1:0]  sh_cap;
    logic [SHEET_REG_W-1:0]  fpr_eff;
    logic                    quarter_turn;
    logic [FRAME_SIDE_W-1:0] disp_w;
    logic [FRAME_SIDE_W-1:0] disp_h;

    always_comb begin
        fw_cap  = (frame_width_reg  > FRAME_CAP) ? FRAME_CAP : frame_width_reg;
        fh_cap  = (frame_height_reg > FRAME_CAP) ? FRAME_CAP : frame_height_reg;
        sw_cap  = (sheet_width_reg  > SHEET_CAP) ? SHEET_CAP : sheet_width_reg;
        sh_cap  = (sheet_height_reg > SHEET_CAP) ? SHEET_CAP : sheet_height_reg;
        fpr_eff = (frames_per_row_reg == '0) ? SHEET_REG_W'(1) : frames_per_row_reg;
        // The quarter-turn orientations all have the top code bit set.
        quarter_turn = orientation_reg[ORIENT_W-1];
        disp_w = quarter_turn ? fh_cap : fw_cap;
        disp_h = quarter_turn ? fw_cap : fh_cap;
    end

    // ------------------------------------------------------------------
    // Pipeline control. The whole pipe moves together while the skid
    // register is empty. When a result reaches a stalled output it parks
    // in the skid register, and the pipe holds until the skid drains, so
    // no requests are taken while a result waits in the skid register.
    // ------------------------------------------------------------------
    logic skid_valid_reg;
    logic pipe_en;

    assign pipe_en = !skid_valid_reg;
    assign s_ready = pipe_en;

    // ------------------------------------------------------------------
    // Input stage: undo the orientation and check the displayed bounds.
    // ------------------------------------------------------------------
    logic [FRAME_SIDE_W-1:0] x_u;
    logic [FRAME_SIDE_W-1:0] y_u;
    logic                    xy_ok;
    logic [FRAME_SIDE_W-1:0] src_x;
    logic [FRAME_SIDE_W-1:0] src_y;
    logic [FRAME_SIDE_W-1:0] flip_x_w;
    logic [FRAME_SIDE_W-1:0] flip_y_w;
    logic [FRAME_SIDE_W-1:0] flip_x_h;
    logic [FRAME_SIDE_W-1:0] flip_y_h;

    always_comb begin
        x_u   = s_screen_x[COORD_W-2:0];
        y_u   = s_screen_y[COORD_W-2:0];
        xy_ok = !s_screen_x[COORD_W-1] && !s_screen_y[COORD_W-1]
                && (x_u < disp_w) && (y_u < disp_h);

        // Mirrored coordinates; they only matter when the position is in bounds,
        // and then they never go negative.
        flip_x_w = fw_cap - FRAME_SIDE_W'(1) - x_u;
        flip_y_w = fw_cap - FRAME_SIDE_W'(1) - y_u;
        flip_x_h = fh_cap - FRAME_SIDE_W'(1) - x_u;
        flip_y_h = fh_cap - FRAME_SIDE_W'(1) - y_u;

        case (orientation_reg)
            ORIENT_MIRROR_ROT180: begin
                src_x = x_u;
                src_y = flip_y_h;
            end
            ORIENT_MIRROR: begin
                src_x = flip_x_w;
                src_y = y_u;
            end
            ORIENT_ROT180: begin
                src_x = flip_x_w;
                src_y = flip_y_h;
            end
            ORIENT_MIRROR_ROT270: begin
                src_x = y_u;
                src_y = x_u;
            end
            ORIENT_ROT90: begin
                src_x = y_u;
                src_y = flip_x_h;
            end
            ORIENT_ROT270: begin
                src_x = flip_y_w;
                src_y = x_u;
            end
            ORIENT_MIRROR_ROT90: begin
                src_x = flip_y_w;
                src_y = flip_x_h;
            end
            default: begin
                src_x = x_u;
                src_y = y_u;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Divider pipeline: frame_number / frames_per_row, restoring division,
    // one quotient bit per stage. Stage 0 is the input register; stage k
    // holds the state after k steps. After the last step dq holds the
    // quotient (frame row) and rem the remainder (frame column).
    // ------------------------------------------------------------------
    logic [DIV_STEPS:0]        div_valid_reg;
    logic [SHEET_REG_W-1:0]    rem_reg  [0:DIV_STEPS];
    logic [FRAME_NUMBER_W-1:0] dq_reg   [0:DIV_STEPS];
    logic [FRAME_SIDE_W-1:0]   sx_reg   [0:DIV_STEPS];
    logic [FRAME_SIDE_W-1:0]   sy_reg   [0:DIV_STEPS];
    logic [DIV_STEPS:0]        ok_reg;

    logic [SHEET_REG_W-1:0]    rem_next [1:DIV_STEPS];
    logic [FRAME_NUMBER_W-1:0] dq_next  [1:DIV_STEPS];
    logic [SHEET_REG_W:0]      trial    [1:DIV_STEPS];
    logic [SHEET_REG_W:0]      trial_sub[1:DIV_STEPS];
    logic                      trial_ge [1:DIV_STEPS];

    always_comb begin
        for (int k = 1; k <= DIV_STEPS; k++) begin
            trial[k]     = {rem_reg[k-1], dq_reg[k-1][FRAME_NUMBER_W-1]};
            trial_sub[k] = trial[k] - {1'b0, fpr_eff};
            trial_ge[k]  = trial[k] >= {1'b0, fpr_eff};
            rem_next[k]  = trial_ge[k] ? trial_sub[k][SHEET_REG_W-1:0]
                                       : trial[k][SHEET_REG_W-1:0];
            dq_next[k]   = {dq_reg[k-1][FRAME_NUMBER_W-2:0], trial_ge[k]};
        end
    end

    // ------------------------------------------------------------------
    // Back-end stages.
    //   P: frame column * frame width and frame row * frame height.
    //   C: add the source position and check against the sheet bounds.
    //   A: sheet row * sheet width.
    // The final add and the out-of-range clear feed the output register.
    // ------------------------------------------------------------------
    logic                    p_valid_reg;
    logic [PX_W-1:0]         px_reg;
    logic [PY_W-1:0]         py_reg;
    logic [FRAME_SIDE_W-1:0] p_sx_reg;
    logic [FRAME_SIDE_W-1:0] p_sy_reg;
    logic                    p_ok_reg;

    logic                    c_valid_reg;
    logic [SIDE_W-1:0]       gx_reg;
    logic [SIDE_W-1:0]       gy_reg;
    logic                    c_ok_reg;

    logic                    a_valid_reg;
    logic [APROD_W-1:0]      aprod_reg;
    logic [SIDE_W-1:0]       a_gx_reg;
    logic                    a_ok_reg;

    logic [PX_W:0]           gx_full;
    logic [PY_W:0]           gy_full;
    logic                    c_ok_next;
    logic [ASUM_W-1:0]       asum;
    logic [AEXT_W-1:0]       asum_ext;
    logic [ADDR_W-1:0]       addr_next;
    logic                    in_range_next;

    always_comb begin
        gx_full   = {1'b0, px_reg} + (PX_W + 1)'(p_sx_reg);
        gy_full   = {1'b0, py_reg} + (PY_W + 1)'(p_sy_reg);
        c_ok_next = p_ok_reg
                    && (gx_full < (PX_W + 1)'(sw_cap))
                    && (gy_full < (PY_W + 1)'(sh_cap));

        asum          = {1'b0, aprod_reg} + ASUM_W'(a_gx_reg);
        asum_ext      = AEXT_W'(asum);
        in_range_next = a_ok_reg;
        addr_next     = a_ok_reg ? asum_ext[ADDR_W-1:0] : '0;
    end

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_valid_reg <= '0;
            p_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            a_valid_reg   <= 1'b0;
        end else if (pipe_en) begin
            div_valid_reg <= {div_valid_reg[DIV_STEPS-1:0], s_valid};
            p_valid_reg   <= div_valid_reg[DIV_STEPS];
            c_valid_reg   <= p_valid_reg;
            a_valid_reg   <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            rem_reg[0] <= '0;
            dq_reg[0]  <= s_frame_number;
            sx_reg[0]  <= src_x;
            sy_reg[0]  <= src_y;
            ok_reg[0]  <= xy_ok;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                rem_reg[k] <= rem_next[k];
                dq_reg[k]  <= dq_next[k];
                sx_reg[k]  <= sx_reg[k-1];
                sy_reg[k]  <= sy_reg[k-1];
                ok_reg[k]  <= ok_reg[k-1];
            end

            px_reg   <= rem_reg[DIV_STEPS] * fw_cap;
            py_reg   <= dq_reg[DIV_STEPS] * fh_cap;
            p_sx_reg <= sx_reg[DIV_STEPS];
            p_sy_reg <= sy_reg[DIV_STEPS];
            p_ok_reg <= ok_reg[DIV_STEPS];

            // In range means both sums are below a sheet side, so they fit SIDE_W.
            gx_reg   <= gx_full[SIDE_W-1:0];
            gy_reg   <= gy_full[SIDE_W-1:0];
            c_ok_reg <= c_ok_next;

            aprod_reg <= gy_reg * sw_cap;
            a_gx_reg  <= gx_reg;
            a_ok_reg  <= c_ok_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid register.
    // ------------------------------------------------------------------
    logic                m_valid_reg;
    logic [ADDR_W-1:0]   m_addr_reg;
    logic                m_in_range_reg;
    logic [ADDR_W-1:0]   skid_addr_reg;
    logic                skid_in_range_reg;
    logic                out_load;
    logic                skid_load;
    logic                skid_drain;

    always_comb begin
        out_load   = pipe_en && (!m_valid_reg || m_ready);
        skid_load  = pipe_en && m_valid_reg && !m_ready && a_valid_reg;
        skid_drain = skid_valid_reg && m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= a_valid_reg;
            end
            if (skid_load) begin
                skid_valid_reg <= 1'b1;
            end else if (skid_drain) begin
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_addr_reg     <= addr_next;
            m_in_range_reg <= in_range_next;
        end else if (skid_drain) begin
            m_addr_reg     <= skid_addr_reg;
            m_in_range_reg <= skid_in_range_reg;
        end
        if (skid_load) begin
            skid_addr_reg     <= addr_next;
            skid_in_range_reg <= in_range_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pixel_address = m_addr_reg;
    assign m_in_range      = m_in_range_reg;

endmodule

FILE: test/pixel_address_checker.sv
// Checker that predicts the sheet address of every pixel request and compares the results.
`timescale 1ns / 1ps

module pixel_address_checker
    import stpa_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic [FRAME_NUMBER_W-1:0] s_frame_number,
    input  logic signed [COORD_W-1:0] s_screen_x,
    input  logic signed [COORD_W-1:0] s_screen_y,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic [ADDR_W-1:0]         m_pixel_address,
    input  logic                      m_in_range,
    output int                        mismatches,
    output int                        outstanding
);

    typedef struct packed {
        logic [ADDR_W-1:0] pixel_address;
        logic              in_range;
    } pixel_result_t;

    // Local copy of the configuration registers.
    logic [FRAME_SIDE_W-1:0] frame_w;
    logic [FRAME_SIDE_W-1:0] frame_h;
    logic [SHEET_REG_W-1:0]  sheet_w;
    logic [SHEET_REG_W-1:0]  sheet_h;
    logic [SHEET_REG_W-1:0]  per_row;
    orient_t                 orient;

    pixel_result_t           pending_pixels[$];

    function automatic longint clip(input longint v, input longint limit);
        return (v > limit) ? limit : v;
    endfunction

    function automatic pixel_result_t lookup_pixel(
        input logic [FRAME_NUMBER_W-1:0] frame,
        input logic signed [COORD_W-1:0] px,
        input logic signed [COORD_W-1:0] py
    );
        longint        fw, fh, sw, sh, fpr, fnum, x, y, dw, dh, col, row, gx, gy;
        pixel_result_t r;
        fw   = clip(frame_w, MAX_FRAME_SIDE_DEFAULT);
        fh   = clip(frame_h, MAX_FRAME_SIDE_DEFAULT);
        sw   = clip(sheet_w, MAX_SHEET_SIDE_DEFAULT);
        sh   = clip(sheet_h, MAX_SHEET_SIDE_DEFAULT);
        fpr  = (per_row == 0) ? 1 : per_row;
        fnum = frame;
        x    = px;
        y    = py;
        r    = '0;
        // The last four orientations are the quarter turns, which swap the shown sides.
        dw = (orient >= ORIENT_MIRROR_ROT270) ? fh : fw;
        dh = (orient >= ORIENT_MIRROR_ROT270) ? fw : fh;
        if (x < 0 || x >= dw || y < 0 || y >= dh)
            return r;
        col = x;
        row = y;
        case (orient)
            ORIENT_MIRROR_ROT180: row = fh - 1 - y;
            ORIENT_MIRROR:        col = fw - 1 - x;
            ORIENT_ROT180: begin
                col = fw - 1 - x;
                row = fh - 1 - y;
            end
            ORIENT_MIRROR_ROT270: begin
                col = y;
                row = x;
            end
            ORIENT_ROT90: begin
                col = y;
                row = fh - 1 - x;
            end
            ORIENT_ROT270: begin
                col = fw - 1 - y;
                row = x;
            end
            ORIENT_MIRROR_ROT90: begin
                col = fw - 1 - y;
                row = fh - 1 - x;
            end
            default: ;
        endcase
        gx = (fnum % fpr) * fw + col;
        gy = (fnum / fpr) * fh + row;
        if (gx < 0 || gx >= sw || gy < 0 || gy >= sh)
            return r;
        r.pixel_address = ADDR_W'(gy * sw + gx);
        r.in_range      = 1'b1;
        return r;
    endfunction

    always @(posedge aclk) begin
        pixel_result_t want;
        logic          bad;
        if (!aresetn) begin
            frame_w = FRAME_WIDTH_RESET;
            frame_h = FRAME_HEIGHT_RESET;
            sheet_w = SHEET_WIDTH_RESET;
            sheet_h = SHEET_HEIGHT_RESET;
            per_row = FRAMES_PER_ROW_RESET;
            orient  = ORIENT_NONE;
            pending_pixels.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FRAME_WIDTH:    frame_w = cfg_data[FRAME_SIDE_W-1:0];
                    REG_FRAME_HEIGHT:   frame_h = cfg_data[FRAME_SIDE_W-1:0];
                    REG_SHEET_WIDTH:    sheet_w = cfg_data;
                    REG_SHEET_HEIGHT:   sheet_h = cfg_data;
                    REG_FRAMES_PER_ROW: per_row = cfg_data;
                    REG_ORIENTATION:    orient  = orient_t'(cfg_data[ORIENT_W-1:0]);
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                pending_pixels = {pending_pixels,
                                  lookup_pixel(s_frame_number, s_screen_x, s_screen_y)};
            if (m_valid && m_ready) begin
                bad = 1'b0;
                if (pending_pixels.size() == 0) begin
                    bad = 1'b1;
                    if (mismatches < 10)
                        $display("%0t: result with no request waiting: address %0d in_range %0b",
                                 $realtime, m_pixel_address, m_in_range);
                end else begin
                    want = pending_pixels.pop_front();
                    if (want.pixel_address !== m_pixel_address ||
                        want.in_range !== m_in_range) begin
                        bad = 1'b1;
                        if (mismatches < 10)
                            $display("%0t: expected address %0d in_range %0b, got %0d %0b",
                                     $realtime, want.pixel_address, want.in_range,
                                     m_pixel_address, m_in_range);
                    end
                end
                if (bad)
                    mismatches <= mismatches + 1;
            end
            outstanding <= pending_pixels.size();
        end
    end

endmodule

FILE: test/testbench.sv
// Top of the sprite pixel address testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import stpa_pkg::*;

    // The block's latency from accepting a request to presenting its result, with no stall.
    localparam int PIPE_LATENCY   = 20;
    // Length of the deliberate result stall, long enough to back up the whole pipeline.
    localparam int HOLD_CYCLES    = 400;
    // Cycles without any handshake before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 50;
    // Register indexes past the end of the map; writes to them must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LOW  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HIGH = 3'd7;

    logic                      aclk           = 1'b0;
    logic                      aresetn        = 1'b0;
    logic                      cfg_valid      = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_W-1:0]    cfg_index      = '0;
    logic [CFG_DATA_W-1:0]     cfg_data       = '0;
    logic                      s_valid        = 1'b0;
    logic                      s_ready;
    logic [FRAME_NUMBER_W-1:0] s_frame_number = '0;
    logic signed [COORD_W-1:0] s_screen_x     = '0;
    logic signed [COORD_W-1:0] s_screen_y     = '0;
    logic                      m_valid;
    logic                      m_ready        = 1'b0;
    logic [ADDR_W-1:0]         m_pixel_address;
    logic                      m_in_range;

    int mismatches;
    int outstanding;
    int quiet_cycles = 0;

    // When set, neither side inserts idle cycles.
    bit steady_flow  = 1'b0;
    // Raised by the stimulus to make the receiver hold off for HOLD_CYCLES.
    bit hold_results = 1'b0;

    // Effective frame geometry of the current setting, used only to aim the stimulus.
    int eff_fw, eff_fh, eff_sh, eff_fpr, disp_w, disp_h;

    sprite_transformed_pixel_address uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_frame_number  (s_frame_number),
        .s_screen_x      (s_screen_x),
        .s_screen_y      (s_screen_y),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_address (m_pixel_address),
        .m_in_range      (m_in_range)
    );

    pixel_address_checker pixel_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_frame_number  (s_frame_number),
        .s_screen_x      (s_screen_x),
        .s_screen_y      (s_screen_y),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_address (m_pixel_address),
        .m_in_range      (m_in_range),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Offers one register write and waits for it to be taken. The caller lowers
    // cfg_valid after the last write of a batch, so back-to-back writes never
    // lower and raise the valid in the same time step.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] reg_index,
                                  input logic [CFG_DATA_W-1:0]  reg_value);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= reg_value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Writes a full setting. It is only called while nothing is in flight.
    task automatic apply_setting(input int fw, input int fh, input int sw, input int sh,
                                 input int fpr, input orient_t orient, input bit with_spares);
        write_register(REG_FRAME_WIDTH, CFG_DATA_W'(fw));
        write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(fh));
        write_register(REG_SHEET_WIDTH, CFG_DATA_W'(sw));
        write_register(REG_SHEET_HEIGHT, CFG_DATA_W'(sh));
        write_register(REG_FRAMES_PER_ROW, CFG_DATA_W'(fpr));
        write_register(REG_ORIENTATION, CFG_DATA_W'(orient));
        if (with_spares) begin
            // All-ones data: if the block aliased these indexes onto a real
            // register, the requests that follow would come out wrong.
            write_register(REG_SPARE_LOW, '1);
            write_register(REG_SPARE_HIGH, '1);
        end
        cfg_valid <= 1'b0;
        // Mirror the block's masking and clamping so the stimulus aims at the frame.
        eff_fw  = fw % 512;
        eff_fh  = fh % 512;
        eff_fw  = (eff_fw > MAX_FRAME_SIDE_DEFAULT) ? MAX_FRAME_SIDE_DEFAULT : eff_fw;
        eff_fh  = (eff_fh > MAX_FRAME_SIDE_DEFAULT) ? MAX_FRAME_SIDE_DEFAULT : eff_fh;
        eff_sh  = (sh > MAX_SHEET_SIDE_DEFAULT) ? MAX_SHEET_SIDE_DEFAULT : sh;
        eff_fpr = (fpr == 0) ? 1 : fpr;
        // Quarter turns show the frame on its side.
        disp_w  = (orient >= ORIENT_MIRROR_ROT270) ? eff_fh : eff_fw;
        disp_h  = (orient >= ORIENT_MIRROR_ROT270) ? eff_fw : eff_fh;
    endtask

    // Presents one request, after a random number of idle cycles unless the
    // flow is steady, and holds it until the block takes it.
    task automatic send_pixel(input logic [FRAME_NUMBER_W-1:0] frame,
                              input logic signed [COORD_W-1:0] px,
                              input logic signed [COORD_W-1:0] py);
        while (!steady_flow && $urandom_range(99) < 34) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_frame_number <= frame;
        s_screen_x     <= px;
        s_screen_y     <= py;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stops offering requests and waits until every predicted result has come back.
    // The checker updates its count with a nonblocking assignment, so the value read
    // at the edge after the last request already includes that request.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // Result side: random back-pressure, steady acceptance on request, and a long
    // hold-off that lets the pipeline fill and push back on the request side.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_results) begin
                hold_results = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= steady_flow || ($urandom_range(99) >= 34);
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

    initial begin
        int                        fw, fh, sw, sh, fpr, rows;
        logic [FRAME_NUMBER_W-1:0] frame;
        logic signed [COORD_W-1:0] px, py;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: one 16x16 frame filling a 16x16 sheet, no orientation.
        // Corners, just past the right, bottom and left edges, the coordinate extremes, and
        // frames that fall off the sheet.
        send_pixel(16'd0, 10'sd0, 10'sd0);
        send_pixel(16'd0, 10'sd15, 10'sd15);
        send_pixel(16'd0, 10'sd16, 10'sd0);
        send_pixel(16'd0, 10'sd0, 10'sd16);
        send_pixel(16'd0, -10'sd1, 10'sd0);
        send_pixel(16'd0, -10'sd512, 10'sd511);
        send_pixel(16'd0, 10'sd511, -10'sd512);
        send_pixel(16'd1, 10'sd3, 10'sd4);
        send_pixel(16'hFFFF, 10'sd0, 10'sd0);
        drain_results();

        // Every orientation on a non-square 5x3 frame in a 4-wide sheet of frames,
        // so a swapped bound shows up. The first setting also pokes the spare indexes.
        for (int o = 0; o < 8; o++) begin
            apply_setting(5, 3, 20, 12, 4, orient_t'(o), o == 0);
            send_pixel(16'd1, 10'sd0, 10'sd0);
            send_pixel(16'd6, COORD_W'(disp_w - 1), COORD_W'(disp_h - 1));
            drain_results();
        end

        // Random phases. The first few pin the register extremes; the rest draw
        // small frames laid out on a sheet that is sometimes a little too narrow or
        // short, so both the frame and the sheet bounds get hit.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                // Oversized frame width (masked to 511, then clamped) and sheet width.
                0: apply_setting(8191, 256, 8191, 4096, 8191, ORIENT_ROT90, 1'b0);
                // Smallest legal geometry.
                1: apply_setting(1, 1, 1, 1, 1, ORIENT_MIRROR_ROT90, 1'b0);
                // Zero frames per row is taken as one.
                2: apply_setting(5, 7, 40, 40, 0, orient_t'($urandom_range(7)), 1'b0);
                // Zero sides: nothing can be in range.
                3: apply_setting(0, 0, 0, 0, 3, orient_t'($urandom_range(7)), 1'b0);
                // Largest frame on the largest sheet.
                4: apply_setting(256, 256, 4096, 4096, 16, orient_t'($urandom_range(7)), 1'b0);
                default: begin
                    fw   = $urandom_range(24, 1);
                    fh   = $urandom_range(24, 1);
                    fpr  = $urandom_range(6, 1);
                    rows = $urandom_range(5, 1);
                    sw   = fpr * fw + int'($urandom_range(4)) - 2;
                    sh   = rows * fh + int'($urandom_range(4)) - 2;
                    apply_setting(fw, fh, (sw < 1) ? 1 : sw, (sh < 1) ? 1 : sh, fpr,
                                  orient_t'($urandom_range(7)), 1'b0);
                end
            endcase

            // One phase runs with no idling on either side; another stalls the
            // result side long enough for the block to refuse new requests.
            steady_flow = (phase == 6);
            if (phase == 8)
                hold_results = 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < 80) begin
                    // Aimed: frames that mostly land on the sheet, positions from
                    // one before the shown sprite to one past it.
                    rows  = eff_sh / ((eff_fh == 0) ? 1 : eff_fh);
                    frame = FRAME_NUMBER_W'($urandom_range(eff_fpr * (rows + 1)));
                    px    = COORD_W'(int'($urandom_range(disp_w + 1)) - 1);
                    py    = COORD_W'(int'($urandom_range(disp_h + 1)) - 1);
                end else begin
                    // Unrestricted values, so every bit of every field toggles.
                    frame = FRAME_NUMBER_W'($urandom);
                    px    = COORD_W'($urandom);
                    py    = COORD_W'($urandom);
                end
                send_pixel(frame, px, py);
            end
            drain_results();
        end
        steady_flow = 1'b0;

        // Give any stray result time to show up before the verdict.
        repeat (2 * PIPE_LATENCY) @(posedge aclk);
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
